// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hmp_pkg.sv -----
// ----------------------------------------------------------------------------
// hmp_pkg
// shared types, constants and helpers of the hash message padder
// ----------------------------------------------------------------------------
package hmp_pkg;

    // default largest block size in bits (512 or 1024)
    localparam int MAX_BLOCK_BITS_DEF = 1024;

    localparam int WORD_BITS    = 64;
    localparam int BYTE_BITS    = 8;
    localparam int WORD_BYTES   = WORD_BITS / BYTE_BITS;
    localparam int NARROW_WORDS = 512 / WORD_BITS;
    localparam int WIDE_BITS    = 1024;

    // padding marker byte: top bit of a byte set
    localparam logic [BYTE_BITS-1:0] PAD_MARKER = 8'(1 << (BYTE_BITS - 1));

    // configuration register word addresses (paddr bit 2)
    localparam logic REG_WIDE_BLOCK        = 1'b0;
    localparam logic REG_LENGTH_BIG_ENDIAN = 1'b1;

    // input word
    typedef struct packed {
        logic [WORD_BITS-1:0] data_word;
        logic [3:0]           byte_count;
        logic                 end_of_message;
    } t_in_item;

    // output word
    typedef struct packed {
        logic [WORD_BITS-1:0] out_word;
        logic                 block_end;
        logic                 message_end;
    } t_out_item;

    // effective configuration
    typedef struct packed {
        logic wide;
        logic big_endian;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic pass;   // load a message word straight into the output register
        logic final_; // take the final word, set up padding
        logic emit;   // load the next padding word into the output register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic last;   // current padding word is the last of the message
    } t_status;

    // reverse the byte order of a word
    function automatic logic [WORD_BITS-1:0] byte_swap(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_BYTES; i++) begin
            r[i*BYTE_BITS +: BYTE_BITS] = w[(WORD_BYTES-1-i)*BYTE_BITS +: BYTE_BITS];
        end
        return r;
    endfunction

endpackage

// ----- rtl/hmp_ctrl.sv -----
// ----------------------------------------------------------------------------
// hmp_ctrl
// controller: input/output handshakes, padding sequence state machine
// ----------------------------------------------------------------------------
module hmp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_eom,
    input  logic            i_out_stall,
    input  hmp_pkg::t_status i_status,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output hmp_pkg::t_cmd   o_cmd
);
    import hmp_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_PAD
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   out_taken;
    logic   in_accept;

    // output register can take a word this cycle
    assign out_free  = !r_out_valid || !i_out_stall;
    assign out_taken = r_out_valid && !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE) || !out_free;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    // command decode and next state
    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !out_taken;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_eom) begin
                        o_cmd.final_ = 1'b1;
                        n_state      = S_PAD;
                    end else begin
                        o_cmd.pass  = 1'b1;
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_PAD: begin
                if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_status.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- rtl/hmp_datapath.sv -----
// ----------------------------------------------------------------------------
// hmp_datapath
// datapath: bit count, block position, padding word build, output register
// ----------------------------------------------------------------------------
module hmp_datapath #(
    parameter int MAX_BLOCK_BITS = hmp_pkg::MAX_BLOCK_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hmp_pkg::t_cfg     i_cfg,
    input  hmp_pkg::t_cmd     i_cmd,
    input  hmp_pkg::t_in_item i_in_item,
    output hmp_pkg::t_status  o_status,
    output hmp_pkg::t_out_item o_out_item
);
    import hmp_pkg::*;

    localparam int MaxWords = MAX_BLOCK_BITS / WORD_BITS;
    localparam int Iw       = $clog2(MaxWords);
    localparam int Cw       = Iw + 1;
    localparam int Sw       = Iw + 2;
    localparam logic [Iw-1:0] NarrowMask = Iw'(NARROW_WORDS - 1);

    logic [WORD_BITS-1:0] r_bit_length;
    logic [Iw-1:0]        r_idx;
    logic [WORD_BITS-1:0] r_partial_word;
    logic [3:0]           r_cnt;
    logic [Cw-1:0]        r_word;
    logic [Cw-1:0]        r_last;
    logic [Cw-1:0]        r_len_at;
    logic [Iw-1:0]        r_pos;
    t_out_item            r_out_item;

    logic [Iw-1:0]        idx_mask;
    logic [Iw-1:0]        idx_cur;
    logic [3:0]           cnt_sat;
    logic [WORD_BITS-1:0] masked_data;
    logic [Sw-1:0]        wpb;
    logic [Sw-1:0]        need;
    logic [Sw-1:0]        words;
    logic [Cw-1:0]        last_idx;
    logic [WORD_BITS-1:0] marker_word;
    logic [WORD_BITS-1:0] len_val;
    logic [WORD_BITS-1:0] pad_word;

    // block geometry for the current mode
    assign idx_mask = i_cfg.wide ? '1 : NarrowMask;
    assign idx_cur  = r_idx & idx_mask;
    assign wpb      = Sw'(idx_mask) + Sw'(1);

    // final word: saturate count, drop bytes beyond it
    assign cnt_sat = (i_in_item.byte_count > 4'(WORD_BYTES)) ? 4'(WORD_BYTES)
                                                              : i_in_item.byte_count;
    always_comb begin
        for (int i = 0; i < WORD_BYTES; i++) begin
            masked_data[i*BYTE_BITS +: BYTE_BITS] =
                (4'(i) < cnt_sat) ? i_in_item.data_word[i*BYTE_BITS +: BYTE_BITS] : '0;
        end
    end

    // words still to send: marker word(s) plus length words, rounded to block end
    assign need     = (cnt_sat[3] ? Sw'(2) : Sw'(1)) + (i_cfg.wide ? Sw'(2) : Sw'(1));
    assign words    = (Sw'(idx_cur) + need <= wpb) ? (wpb - Sw'(idx_cur))
                                                   : ((wpb << 1) - Sw'(idx_cur));
    assign last_idx = Cw'(words - Sw'(1));

    // padding word contents
    assign marker_word = r_cnt[3] ? '0
                                  : (WORD_BITS'(PAD_MARKER) << {r_cnt[2:0], 3'b000});
    assign len_val     = i_cfg.big_endian ? byte_swap(r_bit_length) : r_bit_length;

    always_comb begin
        pad_word = '0;
        if (r_word == '0) begin
            pad_word = r_partial_word | marker_word;
        end
        if (r_word == Cw'(1) && r_cnt[3]) begin
            pad_word = pad_word | WORD_BITS'(PAD_MARKER);
        end
        if (r_word == r_len_at) begin
            pad_word = pad_word | len_val;
        end
    end

    assign o_status.last = (r_word == r_last);

    // message state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_length <= '0;
            r_idx        <= '0;
        end else if (i_cmd.pass) begin
            r_bit_length <= r_bit_length + WORD_BITS'(WORD_BITS);
            r_idx        <= (idx_cur + Iw'(1)) & idx_mask;
        end else if (i_cmd.final_) begin
            r_bit_length <= r_bit_length + WORD_BITS'({cnt_sat, 3'b000});
        end else if (i_cmd.emit && o_status.last) begin
            r_bit_length <= '0;
            r_idx        <= '0;
        end
    end

    // padding sequence registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial_word <= '0;
        end else if (i_cmd.final_) begin
            r_partial_word <= masked_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.final_) begin
            r_cnt    <= cnt_sat;
            r_word   <= '0;
            r_last   <= last_idx;
            r_len_at <= (i_cfg.big_endian || !i_cfg.wide) ? last_idx : last_idx - Cw'(1);
            r_pos    <= idx_cur;
        end else if (i_cmd.emit) begin
            r_word <= r_word + Cw'(1);
            r_pos  <= (r_pos + Iw'(1)) & idx_mask;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.pass) begin
            r_out_item.out_word    <= i_in_item.data_word;
            r_out_item.block_end   <= (idx_cur == idx_mask);
            r_out_item.message_end <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_item.out_word    <= pad_word;
            r_out_item.block_end   <= (r_pos == idx_mask);
            r_out_item.message_end <= o_status.last;
        end
    end

    assign o_out_item = r_out_item;

endmodule

// ----- rtl/hash_message_padder.sv -----
// Message word: registered, on the output in the cycle after it is accepted.
// Throughput: one message word per cycle, outside output stalls and padding.
// Final word: 2 to 19 padding words follow, one per cycle without output stall,
//   from the padding state; input stays stalled until the last one is loaded.
// Reset: synchronous, active low; clears bit count, block position, handshake
//   state and both configuration registers (512-bit blocks, little-endian length).
// ----------------------------------------------------------------------------
// hash_message_padder
// Merkle-Damgard length padding ahead of a hash core, with APB configuration
// ----------------------------------------------------------------------------
module hash_message_padder #(
    parameter int MAX_BLOCK_BITS = hmp_pkg::MAX_BLOCK_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input word channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  hmp_pkg::t_in_item  i_in_item,
    // output word channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output hmp_pkg::t_out_item o_out_item,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import hmp_pkg::*;

    logic    r_wide_block;
    logic    r_length_big_endian;
    logic    cfg_write;
    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    // configuration registers, decoded on the word address
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_block        <= 1'b0;
            r_length_big_endian <= 1'b0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_WIDE_BLOCK:        r_wide_block        <= pwdata[0];
                REG_LENGTH_BIG_ENDIAN: r_length_big_endian <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WIDE_BLOCK:        prdata = {31'b0, r_wide_block};
            REG_LENGTH_BIG_ENDIAN: prdata = {31'b0, r_length_big_endian};
            default:               prdata = '0;
        endcase
    end

    // wide mode only when the block size allows it
    assign cfg.wide       = r_wide_block && (MAX_BLOCK_BITS >= WIDE_BITS);
    assign cfg.big_endian = r_length_big_endian;

    hmp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_eom       (i_in_item.end_of_message),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    hmp_datapath #(
        .MAX_BLOCK_BITS (MAX_BLOCK_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .o_status   (status),
        .o_out_item (o_out_item)
    );

endmodule

// ----- rtl/hmp_checker.sv -----
// ----------------------------------------------------------------------------
// hmp_checker
// port-level checks of the hash message padder, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hmp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input hmp_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input hmp_pkg::t_out_item o_out_item
);
    import hmp_pkg::*;

    logic in_acc;
    logic out_held;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_held = o_out_valid && i_out_stall;

    // stalled output word stays valid and unchanged
    `ASSERT_NEXT(a_out_valid_held, i_clk, i_rst_n, out_held, o_out_valid,
                 "output word dropped under stall")
    `ASSERT_NEXT(a_out_word_held, i_clk, i_rst_n, out_held, $stable(o_out_item),
                 "output word changed under stall")

    // padding ends exactly on a block boundary
    `ASSERT_IMPLIES(a_end_on_block, i_clk, i_rst_n,
                    o_out_valid && o_out_item.message_end, o_out_item.block_end,
                    "message end off block boundary")

    // a message word shows up on the next cycle, not as a message end
    `ASSERT_NEXT(a_pass_next, i_clk, i_rst_n, in_acc && !i_in_item.end_of_message,
                 o_out_valid && !o_out_item.message_end, "message word not passed through")

    // input is held off while padding goes out
    `ASSERT_NEXT(a_stall_padding, i_clk, i_rst_n, in_acc && i_in_item.end_of_message,
                 o_in_stall, "input taken during padding")

endmodule

bind hash_message_padder hmp_checker u_hmp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks hash_message_padder: words stream in with random bursts and gaps,
// results are popped against a behavioral padding predictor while the
// receiver stalls at random, with one long hold-off to back up the input
// ----------------------------------------------------------------------------
module testbench;
    import hmp_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASE_WORDS   = 40;
    localparam int PHASE_COUNT   = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_SLACK   = 8;
    localparam int DIR_COUNT     = 21;
    localparam logic [2:0] ADDR_WIDE = {REG_WIDE_BLOCK, 2'b00};
    localparam logic [2:0] ADDR_BE   = {REG_LENGTH_BIG_ENDIAN, 2'b00};

    // directed row: input word, plus a first result typed in where obvious
    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item lead_word;
    } t_dir_row;

    localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam t_dir_row DIR_ROWS [DIR_COUNT] = '{
        // empty message right after reset
        '{'{ONES, 4'd0, 1'b1}, 1'b1, '{64'h0000_0000_0000_0080, 1'b0, 1'b0}},
        // plain words, count ignored
        '{'{ONES, 4'd0, 1'b0}, 1'b1, '{ONES, 1'b0, 1'b0}},
        '{'{64'h0, 4'd15, 1'b0}, 1'b1, '{64'h0, 1'b0, 1'b0}},
        // count above eight saturates
        '{'{64'h0123_4567_89AB_CDEF, 4'd15, 1'b1}, 1'b1,
          '{64'h0123_4567_89AB_CDEF, 1'b0, 1'b0}},
        // bytes beyond the count are dropped
        '{'{ONES, 4'd3, 1'b1}, 1'b1, '{64'h0000_0000_80FF_FFFF, 1'b0, 1'b0}},
        // seven words then a 7-byte tail: padding spills into a second block
        '{'{64'h1111_2222_3333_4444, 4'd0, 1'b0}, 1'b0, '0},
        '{'{64'h5555_6666_7777_8888, 4'd1, 1'b0}, 1'b0, '0},
        '{'{64'h9999_AAAA_BBBB_CCCC, 4'd2, 1'b0}, 1'b0, '0},
        '{'{64'hDDDD_EEEE_FFFF_0000, 4'd8, 1'b0}, 1'b0, '0},
        '{'{64'h0F0F_0F0F_0F0F_0F0F, 4'd9, 1'b0}, 1'b0, '0},
        '{'{64'hF0F0_F0F0_F0F0_F0F0, 4'd12, 1'b0}, 1'b0, '0},
        '{'{64'hA5A5_5A5A_A5A5_5A5A, 4'd15, 1'b0}, 1'b0, '0},
        '{'{64'hFEDC_BA98_7654_3210, 4'd7, 1'b1}, 1'b0, '0},
        // full final word alone
        '{'{64'h8000_0000_0000_0001, 4'd8, 1'b1}, 1'b0, '0},
        // six words then an empty tail: marker and length fill the block exactly
        '{'{64'h0000_0000_0000_0001, 4'd0, 1'b0}, 1'b0, '0},
        '{'{64'h0000_0000_0000_0002, 4'd0, 1'b0}, 1'b0, '0},
        '{'{64'h0000_0000_0000_0003, 4'd0, 1'b0}, 1'b0, '0},
        '{'{64'h0000_0000_0000_0004, 4'd0, 1'b0}, 1'b0, '0},
        '{'{64'h0000_0000_0000_0005, 4'd0, 1'b0}, 1'b0, '0},
        '{'{64'h0000_0000_0000_0006, 4'd0, 1'b0}, 1'b0, '0},
        '{'{ONES, 4'd0, 1'b1}, 1'b0, '0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hash_message_padder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // predictor state
    logic        cfg_wide;
    logic        cfg_len_be;
    logic [63:0] msg_bits;
    logic [3:0]  blk_word_pos;
    t_out_item   padded_words_q [$];

    int unsigned mismatch_count;
    int unsigned words_accepted;
    int unsigned cycle_count = 0;
    int unsigned burst_left;
    int unsigned msg_words_left;
    logic        msg_open;
    logic        hold_rx;
    logic [5:0]  stall_tick = '0;
    int unsigned stall_level = 0;
    t_out_item   want;

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("mismatch %s: got %h expected %h at cycle %0d",
                 what, got, exp_val, cycle_count);
        mismatch_count++;
    endtask

    // expected words for one accepted input word
    function automatic void predict_padding(input t_in_item it);
        int unsigned blk_bytes, len_bytes, wpb, idx, cnt, start, tail, nwords;
        logic [7:0]  pad_buf [256];
        logic [63:0] v;
        logic        wide;
        t_out_item   res;
        wide      = cfg_wide && (MAX_BLOCK_BITS_DEF >= WIDE_BITS);
        blk_bytes = wide ? 128 : 64;
        len_bytes = wide ? 16 : 8;
        wpb       = blk_bytes / WORD_BYTES;
        idx       = blk_word_pos % wpb;
        // plain message word
        if (!it.end_of_message) begin
            msg_bits += 64'd64;
            res.out_word    = it.data_word;
            res.block_end   = (idx == wpb - 1);
            res.message_end = 1'b0;
            padded_words_q.push_back(res);
            blk_word_pos = 4'((idx + 1) % wpb);
            return;
        end
        // final word: marker, zero fill, length field
        cnt = (it.byte_count > 4'd8) ? 8 : it.byte_count;
        msg_bits += 64'(8 * cnt);
        foreach (pad_buf[i]) pad_buf[i] = 8'h00;
        for (int i = 0; i < int'(cnt); i++) pad_buf[i] = it.data_word[8*i +: 8];
        pad_buf[cnt] = PAD_MARKER;
        start = idx * WORD_BYTES;
        tail  = ((start + cnt + 1 + len_bytes + blk_bytes - 1) / blk_bytes) * blk_bytes
                - start;
        for (int i = 0; i < 8; i++) begin
            if (cfg_len_be) pad_buf[tail - 1 - i] = msg_bits[8*i +: 8];
            else pad_buf[tail - len_bytes + i] = msg_bits[8*i +: 8];
        end
        nwords = tail / WORD_BYTES;
        for (int w = 0; w < int'(nwords); w++) begin
            for (int i = 0; i < 8; i++) v[8*i +: 8] = pad_buf[w*8 + i];
            res.out_word    = v;
            res.block_end   = ((idx + w + 1) % wpb) == 0;
            res.message_end = (w + 1 == nwords);
            padded_words_q.push_back(res);
        end
        msg_bits     = '0;
        blk_word_pos = '0;
    endfunction

    // next random word of a random-length message
    function automatic t_in_item next_message_word();
        t_in_item it;
        int unsigned pick;
        if (!msg_open) begin
            pick = $urandom_range(0, 19);
            if (pick < 16) msg_words_left = $urandom_range(0, 9);
            else if (pick < 19) msg_words_left = $urandom_range(10, 20);
            else msg_words_left = $urandom_range(21, 40);
            msg_open = 1'b1;
        end
        it.data_word = {$urandom, $urandom};
        if (msg_words_left > 0) begin
            msg_words_left--;
            it.byte_count     = 4'($urandom_range(0, 15));
            it.end_of_message = 1'b0;
        end else begin
            it.byte_count     = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 8))
                                                           : 4'($urandom_range(0, 15));
            it.end_of_message = 1'b1;
            msg_open          = 1'b0;
        end
        return it;
    endfunction

    // offer one word in bursts, update the predictor when it is taken
    task automatic send_word(input t_in_item it, input logic typed,
                             input t_out_item lead);
        int unsigned gap, n;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        n = padded_words_q.size();
        predict_padding(it);
        if (typed) padded_words_q[n] = lead;
        words_accepted++;
    endtask

    // stop offering and wait for every expected word to leave
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (padded_words_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    // apb write: setup phase, access phase, then idle
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (addr == ADDR_WIDE) cfg_wide = value[0];
        else cfg_len_be = value[0];
    endtask

    task automatic set_mode(input logic wide, input logic big_endian);
        apb_write(ADDR_WIDE, {31'd0, wide});
        apb_write(ADDR_BE, {31'd0, big_endian});
    endtask

    // receiver: random stall pattern and result check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (padded_words_q.size() == 0) begin
                    report_mismatch("unexpected word", o_out_item.out_word, '0);
                end else begin
                    want = padded_words_q.pop_front();
                    if (o_out_item.out_word !== want.out_word)
                        report_mismatch("out_word", o_out_item.out_word, want.out_word);
                    if (o_out_item.block_end !== want.block_end)
                        report_mismatch("block_end", 64'(o_out_item.block_end),
                                        64'(want.block_end));
                    if (o_out_item.message_end !== want.message_end)
                        report_mismatch("message_end", 64'(o_out_item.message_end),
                                        64'(want.message_end));
                end
            end
            stall_tick <= stall_tick + 6'd1;
            if (stall_tick == 6'd0) stall_level <= $urandom_range(0, 3);
            i_out_stall <= hold_rx || ($urandom_range(0, 7) < 2 * stall_level);
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        hold_rx <= 1'b0;
        wait (words_accepted >= 80);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // main sequence
    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        cfg_wide       = 1'b0;
        cfg_len_be     = 1'b0;
        msg_bits       = '0;
        blk_word_pos   = '0;
        mismatch_count = 0;
        words_accepted = 0;
        burst_left     = 0;
        msg_words_left = 0;
        msg_open       = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, reset configuration
        for (int r = 0; r < DIR_COUNT; r++)
            send_word(DIR_ROWS[r].item, DIR_ROWS[r].typed, DIR_ROWS[r].lead_word);

        // random phases, each under its own mode; messages run across phases
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            drain_block();
            case (ph)
                0: set_mode(1'b1, 1'b0);
                1: set_mode(1'b0, 1'b1);
                2: set_mode(1'b1, 1'b1);
                3: set_mode(1'b0, 1'b0);
                default: set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
            for (int k = 0; k < PHASE_WORDS; k++)
                send_word(next_message_word(), 1'b0, '0);
        end
        while (msg_open) send_word(next_message_word(), 1'b0, '0);

        drain_block();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
